>>> rtl/sc1kf_pkg.sv
// ----------------------------------------------------------------------------
// sc1kf_pkg
// Shared types and constants of the scan code set 1 decoder with key queue.
// ----------------------------------------------------------------------------
package sc1kf_pkg;

   typedef enum logic [1:0] {
      KIND_SCAN  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_QUERY = 2'd3
   } sc1kf_kind_type;

   typedef struct packed {
      sc1kf_kind_type kind;
      logic [7:0]     scan_byte;
      logic [7:0]     key_index;
   } sc1kf_req_type;

   typedef struct packed {
      logic        event_valid;
      logic [10:0] event_code;
      logic        event_pressed;
      logic        buffer_dropped;
      logic        popped_valid;
      logic [10:0] popped_code;
      logic [10:0] head_code;
      logic        key_down;
      logic [7:0]  fill_count;
   } sc1kf_rsp_type;

   // decoded key event and key map write
   typedef struct packed {
      logic        valid;
      logic [10:0] code;
      logic        pressed;
      logic [7:0]  map_idx;
   } sc1kf_event_type;

   // queue status after one step
   typedef struct packed {
      logic       dropped;
      logic       popped;
      logic       nonempty;
      logic [7:0] fill;
   } sc1kf_qstat_type;

   localparam logic [7:0]  BYTE_E0         = 8'd224;
   localparam logic [7:0]  BYTE_E1         = 8'd225;
   localparam logic [7:0]  BYTE_FAKE_SHIFT = 8'd42;
   localparam logic [2:0]  PAUSE_LAST      = 3'd5;
   localparam logic [6:0]  KEY_PAUSE       = 7'd30;
   localparam logic [7:0]  KEY_LCTRL       = 8'd29;
   localparam logic [7:0]  KEY_RCTRL       = 8'd129;
   localparam logic [7:0]  KEY_LSHIFT      = 8'd42;
   localparam logic [7:0]  KEY_RSHIFT      = 8'd54;
   localparam logic [7:0]  KEY_LALT        = 8'd56;
   localparam logic [7:0]  KEY_RALT        = 8'd156;
   localparam logic [7:0]  IDX_PAUSE       = 8'd130;
   localparam logic [6:0]  NORMAL_MAX      = 7'd88;
   localparam logic [6:0]  EXT_MAX         = 7'd83;
   localparam logic [7:0]  EXT_IDX_OFS     = 8'd100;
   localparam logic [10:0] EXT_CODE_OFS    = 11'd100;
   localparam logic [10:0] SHIFT_OFS       = 11'd256;
   localparam logic [10:0] CTRL_OFS        = 11'd512;
   localparam logic [10:0] ALT_OFS         = 11'd1024;
   localparam logic [7:0]  LIMIT_RESET     = 8'd128;

endpackage

>>> rtl/sc1kf_ram.sv
// ----------------------------------------------------------------------------
// sc1kf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sc1kf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sc1kf_decode.sv
// ----------------------------------------------------------------------------
// sc1kf_decode
// Scan byte decoder: prefix and pause sequence tracking, modifier shadows,
// key coding and key map write address.
// ----------------------------------------------------------------------------
module sc1kf_decode
   import sc1kf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      scan_byte,
   input  logic [7:0]      key_index,
   output sc1kf_event_type event_out,
   output logic            shadow_hit,
   output logic            shadow_bit
);

   logic [2:0]  pause_ff, pause_in;
   logic        ext_ff, ext_in, ext_mid;
   logic        lctrl_ff, lctrl_in, rctrl_ff, rctrl_in;
   logic        lshift_ff, lshift_in, rshift_ff, rshift_in;
   logic        lalt_ff, lalt_in, ralt_ff, ralt_in;
   logic        pkey_ff, pkey_in;
   logic [6:0]  key;
   logic [7:0]  key8;
   logic        pressed;
   logic        inrange;
   logic [10:0] base;
   logic [10:0] code;
   logic [7:0]  idx;
   logic        hit;

   always_comb begin
      pause_in = pause_ff;
      ext_mid  = ext_ff;
      key      = 7'd0;
      pressed  = 1'b0;
      if (pause_ff == 3'd0 && scan_byte != BYTE_E1) begin
         if (ext_ff && scan_byte == BYTE_FAKE_SHIFT) begin
            ext_mid = 1'b0;
         end else if (!ext_ff && scan_byte == BYTE_E0) begin
            ext_mid = 1'b1;
         end else begin
            key     = scan_byte[6:0];
            pressed = !scan_byte[7];
         end
      end else if (pause_ff < PAUSE_LAST) begin
         pause_in = pause_ff + 3'd1;
         ext_mid  = 1'b0;
      end else begin
         pause_in = 3'd0;
         ext_mid  = 1'b1;
         key      = KEY_PAUSE;
         pressed  = 1'b1;
      end
      ext_in = (key != 7'd0) ? 1'b0 : ext_mid;

      key8 = {1'b0, key};
      base = {4'd0, key};
      code = base;
      if ((lshift_ff || rshift_ff) && key8 != KEY_LSHIFT && key8 != KEY_RSHIFT) begin
         code = base + SHIFT_OFS;
      end
      if ((lctrl_ff || rctrl_ff) && key8 != KEY_LCTRL && key8 != KEY_RCTRL) begin
         code = base + CTRL_OFS;
      end
      if ((lalt_ff || ralt_ff) && key8 != KEY_LALT && key8 != KEY_RALT) begin
         code = base + ALT_OFS;
      end
      if (ext_mid) begin
         code    = code + EXT_CODE_OFS;
         inrange = key <= EXT_MAX;
         idx     = key8 + EXT_IDX_OFS;
      end else begin
         inrange = key <= NORMAL_MAX;
         idx     = key8;
      end

      hit = step && key != 7'd0 && inrange;
      event_out.valid   = hit;
      event_out.code    = code;
      event_out.pressed = pressed;
      event_out.map_idx = idx;

      lctrl_in  = (hit && idx == KEY_LCTRL)  ? pressed : lctrl_ff;
      rctrl_in  = (hit && idx == KEY_RCTRL)  ? pressed : rctrl_ff;
      lshift_in = (hit && idx == KEY_LSHIFT) ? pressed : lshift_ff;
      rshift_in = (hit && idx == KEY_RSHIFT) ? pressed : rshift_ff;
      lalt_in   = (hit && idx == KEY_LALT)   ? pressed : lalt_ff;
      ralt_in   = (hit && idx == KEY_RALT)   ? pressed : ralt_ff;
      // any decoded key releases pause first
      if (step && key != 7'd0) begin
         pkey_in = (hit && idx == IDX_PAUSE) ? pressed : 1'b0;
      end else begin
         pkey_in = pkey_ff;
      end
   end

   always_comb begin
      unique case (key_index)
         KEY_LCTRL:  begin shadow_hit = 1'b1; shadow_bit = lctrl_ff;  end
         KEY_RCTRL:  begin shadow_hit = 1'b1; shadow_bit = rctrl_ff;  end
         KEY_LSHIFT: begin shadow_hit = 1'b1; shadow_bit = lshift_ff; end
         KEY_RSHIFT: begin shadow_hit = 1'b1; shadow_bit = rshift_ff; end
         KEY_LALT:   begin shadow_hit = 1'b1; shadow_bit = lalt_ff;   end
         KEY_RALT:   begin shadow_hit = 1'b1; shadow_bit = ralt_ff;   end
         IDX_PAUSE:  begin shadow_hit = 1'b1; shadow_bit = pkey_ff;   end
         default:    begin shadow_hit = 1'b0; shadow_bit = 1'b0;      end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_ff  <= 3'd0;
         ext_ff    <= 1'b0;
         lctrl_ff  <= 1'b0;
         rctrl_ff  <= 1'b0;
         lshift_ff <= 1'b0;
         rshift_ff <= 1'b0;
         lalt_ff   <= 1'b0;
         ralt_ff   <= 1'b0;
         pkey_ff   <= 1'b0;
      end else if (step) begin
         pause_ff  <= pause_in;
         ext_ff    <= ext_in;
         lctrl_ff  <= lctrl_in;
         rctrl_ff  <= rctrl_in;
         lshift_ff <= lshift_in;
         rshift_ff <= rshift_in;
         lalt_ff   <= lalt_in;
         ralt_ff   <= ralt_in;
         pkey_ff   <= pkey_in;
      end
   end

endmodule

>>> rtl/sc1kf_queue.sv
// ----------------------------------------------------------------------------
// sc1kf_queue
// Key code queue: head and fill tracking around a RAM, with the head entry
// read back in the cycle after each step.
// ----------------------------------------------------------------------------
module sc1kf_queue
   import sc1kf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  sc1kf_kind_type  kind,
   input  logic            push,
   input  logic [10:0]     push_code,
   input  logic [7:0]      limit,
   output sc1kf_qstat_type qstat,
   output logic [10:0]     head_data
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;

   logic [PTR_W-1:0]  head_ff, head_in, head_inc;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [8:0]        eff_limit;
   logic              can_push;
   logic [SUM_W-1:0]  wr_sum;
   logic [PTR_W-1:0]  wr_addr;
   logic              wr_en;
   logic              fwd_ff;
   logic [10:0]       fwd_data_ff;
   logic [10:0]       rd_data;

   always_comb begin
      eff_limit = ({1'b0, limit} > 9'(QUEUE_DEPTH)) ? 9'(QUEUE_DEPTH) : {1'b0, limit};
      can_push  = 9'(fill_ff) < eff_limit;
      wr_sum    = SUM_W'(head_ff) + SUM_W'(fill_ff);
      wr_addr   = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH))
                                                  : PTR_W'(wr_sum);
      head_inc  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      wr_en     = 1'b0;
      head_in   = head_ff;
      fill_in   = fill_ff;
      qstat.dropped = 1'b0;
      qstat.popped  = 1'b0;
      case (kind)
         KIND_SCAN: begin
            if (push) begin
               if (can_push) begin
                  wr_en   = step;
                  fill_in = fill_ff + FILL_W'(1);
               end else begin
                  qstat.dropped = 1'b1;
               end
            end
         end
         KIND_POP: begin
            if (fill_ff != '0) begin
               qstat.popped = 1'b1;
               head_in      = head_inc;
               fill_in      = fill_ff - FILL_W'(1);
            end
         end
         KIND_CLEAR: begin
            head_in = '0;
            fill_in = '0;
         end
         default: begin
         end
      endcase
      qstat.nonempty = fill_in != '0;
      qstat.fill     = 8'(fill_in);
   end

   sc1kf_ram #(
      .WIDTH (11),
      .DEPTH (QUEUE_DEPTH)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_code),
      .rd_en   (step),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         fwd_ff  <= 1'b0;
      end else if (step) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         fwd_ff  <= wr_en && wr_addr == head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         fwd_data_ff <= push_code;
      end
   end

   assign head_data = fwd_ff ? fwd_data_ff : rd_data;

endmodule

>>> rtl/scancode_set1_decoder_with_key_fifo.sv
// ----------------------------------------------------------------------------
// scancode_set1_decoder_with_key_fifo
// Scan code set 1 decoder with key-down map and buffered key code queue.
//
//   port group   dir   handshake             word
//   req_         in    req_valid/req_ready   sc1kf_req_type
//   rsp_         out   rsp_valid/rsp_ready   sc1kf_rsp_type
//   csr_         in    csr_wr_en             8-bit buffer limit
//
// One word per cycle unless the output stalls; a response passes the RAM read
// stage of the key map and code queue RAMs, then the output register.
// After reset all 256 key map RAM entries are swept clear, with req_ready
// low; csr writes are taken during the sweep.
// A stalled response holds in the output register while one more request
// is taken into the RAM read stage.
// ----------------------------------------------------------------------------
module scancode_set1_decoder_with_key_fifo
   import sc1kf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  sc1kf_req_type req_word,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output sc1kf_rsp_type rsp_word,
   input  logic          csr_wr_en,
   input  logic [7:0]    csr_wr_data
);

   logic [7:0]      limit_ff;
   logic            clr_busy_ff;
   logic [7:0]      clr_cnt_ff;
   logic            accept, scan_step;
   logic            out_free, s1_move;
   sc1kf_event_type ev;
   logic            shadow_hit, shadow_bit;
   sc1kf_qstat_type qstat;
   logic [10:0]     head_data;
   logic            map_we;
   logic [7:0]      map_waddr;
   logic            map_wdata;
   logic            map_q;

   logic            s1_valid_ff, s1_valid_in;
   sc1kf_kind_type  s1_kind_ff;
   sc1kf_event_type s1_ev_ff;
   sc1kf_qstat_type s1_qstat_ff;
   logic            s1_shit_ff, s1_sbit_ff;
   logic            out_valid_ff, out_valid_in;
   sc1kf_rsp_type   out_ff, out_in;
   logic [10:0]     hv_ff;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || out_free);
   assign accept    = req_valid && req_ready;
   assign scan_step = accept && req_word.kind == KIND_SCAN;

   sc1kf_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (scan_step),
      .scan_byte  (req_word.scan_byte),
      .key_index  (req_word.key_index),
      .event_out  (ev),
      .shadow_hit (shadow_hit),
      .shadow_bit (shadow_bit)
   );

   sc1kf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .kind      (req_word.kind),
      .push      (ev.valid && ev.pressed),
      .push_code (ev.code),
      .limit     (limit_ff),
      .qstat     (qstat),
      .head_data (head_data)
   );

   always_comb begin
      if (clr_busy_ff) begin
         map_we    = 1'b1;
         map_waddr = clr_cnt_ff;
         map_wdata = 1'b0;
      end else begin
         map_we    = ev.valid;
         map_waddr = ev.map_idx;
         map_wdata = ev.pressed;
      end
   end

   sc1kf_ram #(
      .WIDTH (1),
      .DEPTH (256)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (accept),
      .rd_addr (req_word.key_index),
      .rd_data (map_q)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && !rsp_ready);

      out_in.event_valid    = s1_ev_ff.valid;
      out_in.event_code     = s1_ev_ff.valid ? s1_ev_ff.code : 11'd0;
      out_in.event_pressed  = s1_ev_ff.valid && s1_ev_ff.pressed;
      out_in.buffer_dropped = s1_qstat_ff.dropped;
      out_in.popped_valid   = s1_qstat_ff.popped;
      out_in.popped_code    = s1_qstat_ff.popped ? hv_ff : 11'd0;
      out_in.head_code      = s1_qstat_ff.nonempty ? head_data : 11'd0;
      if (s1_kind_ff == KIND_QUERY) begin
         out_in.key_down = s1_shit_ff ? s1_sbit_ff : map_q;
      end else begin
         out_in.key_down = 1'b0;
      end
      out_in.fill_count = s1_qstat_ff.fill;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= 8'd0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 8'd1;
            if (clr_cnt_ff == 8'hff) begin
               clr_busy_ff <= 1'b0;
            end
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_word.kind;
         s1_ev_ff    <= ev;
         s1_qstat_ff <= qstat;
         s1_shit_ff  <= shadow_hit;
         s1_sbit_ff  <= shadow_bit;
      end
      if (s1_move) begin
         out_ff <= out_in;
         hv_ff  <= out_in.head_code;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

`ifndef SYNTHESIS
   a_drop_is_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.buffer_dropped |-> rsp_word.event_valid && rsp_word.event_pressed)
      else $error("drop flagged without a press event");

   a_head_needs_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.head_code != 11'd0 |-> rsp_word.fill_count != 8'd0)
      else $error("head code shown on an empty queue");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("read stage lost a word during output stall");

   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> $past(clr_cnt_ff) == 8'hff)
      else $error("key map sweep ended early");
`endif

endmodule
